// ===== rtl/xdk_pkg.sv =====
// Package for the XOR-distance k-closest list unit.
// Holds the request, response and cell types and the operation codes.
// Depends on nothing; every rtl file refers to it by scoped names.
package xdk_pkg;

   // Configuration port geometry: four 64-bit target registers at 8-byte spacing.
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 64;
   localparam int ID_W       = 256;

   // Operation codes of a request.
   typedef enum logic [1:0] {
      FUNC_CHECK  = 2'd0,
      FUNC_RECORD = 2'd1,
      FUNC_READ   = 2'd2,
      FUNC_CLEAR  = 2'd3
   } func_type;

   // Outcome codes of a response.
   typedef enum logic [2:0] {
      OUT_INSERTED  = 3'd0,
      OUT_DUPLICATE = 3'd1,
      OUT_DROPPED   = 3'd2,
      OUT_ZERO_ID   = 3'd3,
      OUT_NO_RECORD = 3'd4
   } outcome_type;

   // Target register indexes.
   typedef enum logic [1:0] {
      REG_TARGET0 = 2'd0,
      REG_TARGET1 = 2'd1,
      REG_TARGET2 = 2'd2,
      REG_TARGET3 = 2'd3
   } reg_index_type;

   typedef enum logic {
      ST_IDLE,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [63:0] id_word0;
      logic [63:0] id_word1;
      logic [63:0] id_word2;
      logic [63:0] id_word3;
      logic [31:0] peer_ip;
      logic [15:0] peer_port;
      logic [4:0]  read_index;
   } req_type;

   typedef struct packed {
      logic        closer;
      logic [2:0]  outcome;
      logic [4:0]  position;
      logic [4:0]  entry_count;
      logic [63:0] out_word0;
      logic [63:0] out_word1;
      logic [63:0] out_word2;
      logic [63:0] out_word3;
      logic [31:0] out_ip;
      logic [15:0] out_port;
      logic        entry_valid;
   } rsp_type;

   // One list entry as held in a cell.
   typedef struct packed {
      logic [ID_W-1:0] id;
      logic [31:0]     ip;
      logic [15:0]     port;
   } entry_type;

   // Strobes from the controller to every cell.
   typedef struct packed {
      logic capture;   // latch the distance comparison for a new request
      logic commit;    // perform the sorted insert
   } cell_ctrl_type;

endpackage

// ===== rtl/xor_distance_k_closest_list_unit.sv =====
// Top level of the XOR-distance k-closest list unit.
// Uses xdk_pkg and a chain of xdk_cell instances, one per list slot.
//
//   Channel   Direction  Handshake            Payload
//   req       in         req_valid/req_stall  xdk_pkg::req_type
//   rsp       out        rsp_valid/rsp_stall  xdk_pkg::rsp_type
//   csr       in         APB-style, 64 bit    target registers at 8*i
//
// Each request has an accept cycle, which latches the distance comparison in
// every cell, and an update cycle, which inserts, reads or clears.
// The update cycle waits while an earlier response is still held and stalled.
// Reset is synchronous and clears the entry count, targets and handshake state;
// list contents are not cleared and no clearing pass is needed.
module xor_distance_k_closest_list_unit #(
   parameter int LIST_DEPTH = 20
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  xdk_pkg::req_type               req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output xdk_pkg::rsp_type               rsp_payload,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [xdk_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [xdk_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [xdk_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);

   localparam int CNT_W = $clog2(LIST_DEPTH + 1);

   xdk_pkg::state_type     state_ff, state_in;
   xdk_pkg::req_type       req_ff, req_in;
   xdk_pkg::rsp_type       rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]       held_count_ff, held_count_in;
   logic [xdk_pkg::ID_W-1:0] target_ff, target_in;

   logic                   req_accept;
   logic                   finish;
   logic                   csr_write;
   xdk_pkg::cell_ctrl_type cell_ctrl;
   xdk_pkg::entry_type     new_entry;
   xdk_pkg::entry_type     cell_entry [LIST_DEPTH];
   logic [LIST_DEPTH-1:0]  hold_vec;
   logic [LIST_DEPTH-1:0]  equal_vec;
   logic [LIST_DEPTH-1:0]  run_vec;
   logic [LIST_DEPTH-1:0]  left_run_vec;
   logic [LIST_DEPTH-1:0]  occupied_vec;
   logic [xdk_pkg::ID_W-1:0] req_id;
   logic [CNT_W-1:0]       ins_pos;
   logic [5:0]             pos_wide;
   logic [5:0]             count_wide;
   logic                   dup;
   logic                   zero_id;
   logic                   list_full;
   logic                   do_insert;
   xdk_pkg::entry_type     read_entry;
   logic                   read_valid;

   // Configuration port: always ready, register picked by address bits 4..3.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      target_in = target_ff;
      if (csr_write) begin
         case (xdk_pkg::reg_index_type'(csr_paddr[4:3]))
            xdk_pkg::REG_TARGET0: target_in[255:192] = csr_pwdata;
            xdk_pkg::REG_TARGET1: target_in[191:128] = csr_pwdata;
            xdk_pkg::REG_TARGET2: target_in[127:64]  = csr_pwdata;
            xdk_pkg::REG_TARGET3: target_in[63:0]    = csr_pwdata;
            default:              target_in = target_ff;
         endcase
      end
   end

   always_comb begin
      case (xdk_pkg::reg_index_type'(csr_paddr[4:3]))
         xdk_pkg::REG_TARGET0: csr_prdata = target_ff[255:192];
         xdk_pkg::REG_TARGET1: csr_prdata = target_ff[191:128];
         xdk_pkg::REG_TARGET2: csr_prdata = target_ff[127:64];
         xdk_pkg::REG_TARGET3: csr_prdata = target_ff[63:0];
         default:              csr_prdata = '0;
      endcase
   end

   // Handshake and sequencing.
   assign req_accept = req_valid && !req_stall;
   assign finish     = (state_ff == xdk_pkg::ST_UPDATE) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         xdk_pkg::ST_IDLE:   if (req_accept) state_in = xdk_pkg::ST_UPDATE;
         xdk_pkg::ST_UPDATE: if (finish) state_in = xdk_pkg::ST_IDLE;
         default:            state_in = xdk_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall         = 1'b1;
      cell_ctrl.capture = 1'b0;
      cell_ctrl.commit  = 1'b0;
      case (state_ff)
         xdk_pkg::ST_IDLE: begin
            req_stall         = 1'b0;
            cell_ctrl.capture = req_valid;
         end
         xdk_pkg::ST_UPDATE: begin
            cell_ctrl.commit = finish && do_insert;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   assign req_in = req_accept ? req_payload : req_ff;
   assign req_id = {req_payload.id_word0, req_payload.id_word1,
                    req_payload.id_word2, req_payload.id_word3};

   assign new_entry.id   = {req_ff.id_word0, req_ff.id_word1,
                            req_ff.id_word2, req_ff.id_word3};
   assign new_entry.ip   = req_ff.peer_ip;
   assign new_entry.port = req_ff.peer_port;

   // The chain of list cells; slot 0 is the nearest entry. Each cell passes on
   // whether it and every cell before it hold entries nearer than the id.
   for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
      assign occupied_vec[i] = CNT_W'(i) < held_count_ff;
      if (i == 0) begin : g_head
         assign left_run_vec[i] = 1'b1;
         xdk_cell u_cell (
            .clock      (clock),
            .ctrl       (cell_ctrl),
            .target     (target_ff),
            .req_id     (req_id),
            .occupied   (occupied_vec[i]),
            .new_entry  (new_entry),
            .left_entry (new_entry),
            .left_run   (left_run_vec[i]),
            .entry      (cell_entry[i]),
            .run        (run_vec[i]),
            .hold       (hold_vec[i]),
            .equal      (equal_vec[i])
         );
      end else begin : g_body
         assign left_run_vec[i] = run_vec[i-1];
         xdk_cell u_cell (
            .clock      (clock),
            .ctrl       (cell_ctrl),
            .target     (target_ff),
            .req_id     (req_id),
            .occupied   (occupied_vec[i]),
            .new_entry  (new_entry),
            .left_entry (cell_entry[i-1]),
            .left_run   (left_run_vec[i]),
            .entry      (cell_entry[i]),
            .run        (run_vec[i]),
            .hold       (hold_vec[i]),
            .equal      (equal_vec[i])
         );
      end
   end

   // Insert position: the length of the run of nearer entries at the head.
   always_comb begin
      ins_pos = '0;
      for (int i = 0; i < LIST_DEPTH; i++) begin
         if (run_vec[i]) begin
            ins_pos = CNT_W'(i + 1);
         end
      end
   end

   // The entries in the run and the first entry after it are examined for a duplicate.
   assign dup       = |(equal_vec & left_run_vec);
   assign zero_id   = (new_entry.id == '0);
   assign list_full = (held_count_ff == CNT_W'(LIST_DEPTH));
   assign do_insert = (xdk_pkg::func_type'(req_ff.func) == xdk_pkg::FUNC_RECORD) &&
                      !zero_id && !dup && !run_vec[LIST_DEPTH-1];
   assign pos_wide  = 6'(ins_pos);

   // Read selection over the cell outputs.
   always_comb begin
      read_entry = '0;
      for (int i = 0; i < LIST_DEPTH; i++) begin
         if (req_ff.read_index == 5'(i)) begin
            read_entry = cell_entry[i];
         end
      end
   end
   assign read_valid = (6'(req_ff.read_index) < 6'(held_count_ff));

   // Entry count after the request.
   always_comb begin
      held_count_in = held_count_ff;
      if (finish) begin
         if (xdk_pkg::func_type'(req_ff.func) == xdk_pkg::FUNC_CLEAR) begin
            held_count_in = '0;
         end else if (do_insert && !list_full) begin
            held_count_in = held_count_ff + CNT_W'(1);
         end
      end
   end
   assign count_wide = 6'(held_count_in);

   // Response assembly.
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (finish) begin
         rsp_valid_in       = 1'b1;
         rsp_in             = '0;
         rsp_in.outcome     = xdk_pkg::OUT_NO_RECORD;
         rsp_in.entry_count = count_wide[4:0];
         case (xdk_pkg::func_type'(req_ff.func))
            xdk_pkg::FUNC_CHECK: begin
               rsp_in.closer = !list_full ||
                               (!hold_vec[LIST_DEPTH-1] && !equal_vec[LIST_DEPTH-1]);
            end
            xdk_pkg::FUNC_RECORD: begin
               rsp_in.closer = !list_full ||
                               (!hold_vec[LIST_DEPTH-1] && !equal_vec[LIST_DEPTH-1]);
               if (zero_id) begin
                  rsp_in.outcome = xdk_pkg::OUT_ZERO_ID;
               end else if (dup) begin
                  rsp_in.outcome = xdk_pkg::OUT_DUPLICATE;
               end else if (run_vec[LIST_DEPTH-1]) begin
                  rsp_in.outcome = xdk_pkg::OUT_DROPPED;
               end else begin
                  rsp_in.outcome  = xdk_pkg::OUT_INSERTED;
                  rsp_in.position = pos_wide[4:0];
               end
            end
            xdk_pkg::FUNC_READ: begin
               if (read_valid) begin
                  rsp_in.entry_valid = 1'b1;
                  rsp_in.out_word0   = read_entry.id[255:192];
                  rsp_in.out_word1   = read_entry.id[191:128];
                  rsp_in.out_word2   = read_entry.id[127:64];
                  rsp_in.out_word3   = read_entry.id[63:0];
                  rsp_in.out_ip      = read_entry.ip;
                  rsp_in.out_port    = read_entry.port;
               end
            end
            default: begin
               rsp_in.closer = 1'b0;
            end
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= xdk_pkg::ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         held_count_ff <= '0;
         target_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         held_count_ff <= held_count_in;
         target_ff     <= target_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   // The entry count never exceeds the list depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      held_count_ff <= CNT_W'(LIST_DEPTH))
      else $error("entry count above list depth");

   // The cells that stay in place form a prefix of the list.
   a_sorted_prefix: assert property (@(posedge clock) disable iff (reset)
      (state_ff == xdk_pkg::ST_UPDATE) |-> (((run_vec >> 1) & ~run_vec) == '0))
      else $error("staying cells are not a prefix");

   // At most one entry is flagged as a duplicate.
   a_single_match: assert property (@(posedge clock) disable iff (reset)
      (state_ff == xdk_pkg::ST_UPDATE) |-> $onehot0(equal_vec & left_run_vec))
      else $error("id matches more than one entry");

   // A finished clear leaves the list empty.
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (finish && (xdk_pkg::func_type'(req_ff.func) == xdk_pkg::FUNC_CLEAR))
      |=> (held_count_ff == '0))
      else $error("clear did not empty the list");

   // A new response only appears at the end of an update cycle.
   a_rsp_from_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == xdk_pkg::ST_UPDATE))
      else $error("response raised outside an update");

endmodule

// ===== rtl/xdk_cell.sv =====
// One cell of the sorted list: holds an entry and compares it to a request.
// Uses xdk_pkg; instantiated in a chain by xor_distance_k_closest_list_unit.
module xdk_cell (
   input  logic                     clock,
   input  xdk_pkg::cell_ctrl_type   ctrl,
   input  logic [xdk_pkg::ID_W-1:0] target,
   input  logic [xdk_pkg::ID_W-1:0] req_id,
   input  logic                     occupied,
   input  xdk_pkg::entry_type       new_entry,
   input  xdk_pkg::entry_type       left_entry,
   input  logic                     left_run,
   output xdk_pkg::entry_type       entry,
   output logic                     run,
   output logic                     hold,
   output logic                     equal
);

   xdk_pkg::entry_type entry_ff, entry_in;
   logic               hold_ff, hold_in;
   logic               equal_ff, equal_in;
   logic [xdk_pkg::ID_W-1:0] dist_entry, dist_req;

   // Distance comparison against the incoming request.
   always_comb begin
      dist_entry = entry_ff.id ^ target;
      dist_req   = req_id ^ target;
      hold_in    = hold_ff;
      equal_in   = equal_ff;
      if (ctrl.capture) begin
         hold_in  = occupied && (dist_entry < dist_req);
         equal_in = occupied && (entry_ff.id == req_id);
      end
   end

   // A cell stays put while it and every cell before it hold nearer entries.
   // The first cell that breaks this run takes the new entry, and the cells
   // after it take their left neighbor's entry.
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.commit && !run) begin
         if (left_run) begin
            entry_in = new_entry;
         end else begin
            entry_in = left_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      hold_ff  <= hold_in;
      equal_ff <= equal_in;
   end

   assign entry = entry_ff;
   assign run   = left_run && hold_ff;
   assign hold  = hold_ff;
   assign equal = equal_ff;

endmodule
